/* rtl/gqcs_pkg.sv */
// Shared widths and constants for the global quantile contrast stretch block.
package gqcs_pkg;

  localparam int COUNT_BITS = 22;
  localparam int BIN_COUNT  = 256;
  localparam int BIN_BITS   = $clog2(BIN_COUNT);
  localparam int PIX_BITS   = 8;
  localparam int LVL_BITS   = 9;
  localparam int Q_BITS     = 14;
  localparam int TGT_BITS   = COUNT_BITS + Q_BITS;
  localparam int RUN_BITS   = TGT_BITS + BIN_BITS;
  localparam int DIV_STEPS  = PIX_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [Q_BITS-1:0]     FULL_SCALE = Q_BITS'(10000);
  localparam logic [Q_BITS-1:0]     Q_RESET    = Q_BITS'(9500);
  localparam logic [LVL_BITS-1:0]   WL_RESET   = LVL_BITS'(255);
  localparam logic [PIX_BITS-1:0]   PIX_MAX    = '1;
  localparam logic [BIN_BITS-1:0]   LAST_BIN   = BIN_BITS'(BIN_COUNT - 1);

  localparam logic MODE_ACC = 1'b0;
  localparam logic MODE_MAP = 1'b1;

endpackage

/* rtl/global_quantile_contrast_stretch.sv */
// Accumulate: each pixel reads its histogram bin, then increments and writes it back.
// Map: zero or over-level pixels go straight to the result register; other pixels
//   first run the 8-step restoring divider. No new request is taken until the result is emitted.
// Level search after the last pixel: read, multiply and add steps for each bin walked,
//   up to 256 bins, then difference, finish and emit steps; one report per pass.
// Reset: synchronous, active low; histogram valid bits clear together, no sweep.
module global_quantile_contrast_stretch (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [gqcs_pkg::Q_BITS-1:0]            cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_mode,
  input  logic [gqcs_pkg::PIX_BITS-1:0]          in_pixel,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [gqcs_pkg::PIX_BITS-1:0]          out_mapped_pixel,
  output logic signed [gqcs_pkg::LVL_BITS-1:0]   out_quantile_level,
  output logic                                   out_is_level_report
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_UPD,
    S_TGT,
    S_W_RD,
    S_W_MUL,
    S_W_ADD,
    S_DIF,
    S_FIN,
    S_MAP,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state_r;

  // histogram memory
  logic [gqcs_pkg::COUNT_BITS-1:0] mem [gqcs_pkg::BIN_COUNT];
  logic [gqcs_pkg::BIN_COUNT-1:0]  bin_vld_r;
  logic [gqcs_pkg::BIN_BITS-1:0]   mem_raddr;
  logic [gqcs_pkg::COUNT_BITS-1:0] rd_data_r;
  logic                            rd_vld_r;
  logic [gqcs_pkg::COUNT_BITS-1:0] bin_val;
  logic [gqcs_pkg::COUNT_BITS-1:0] bin_inc;
  logic                            mem_we;

  logic [gqcs_pkg::Q_BITS-1:0]     quantile_r;
  logic [gqcs_pkg::Q_BITS-1:0]     q_clamp;
  logic [gqcs_pkg::COUNT_BITS-1:0] total_r;
  logic signed [gqcs_pkg::LVL_BITS-1:0] white_r;

  logic [gqcs_pkg::PIX_BITS-1:0]   pix_r;
  logic                            last_r;

  // search datapath
  logic [gqcs_pkg::BIN_BITS-1:0]   idx_r;
  logic [gqcs_pkg::TGT_BITS-1:0]   target_r;
  logic [gqcs_pkg::TGT_BITS-1:0]   prod_r;
  logic [gqcs_pkg::RUN_BITS-1:0]   run_r;
  logic [gqcs_pkg::RUN_BITS-1:0]   prev_r;
  logic [gqcs_pkg::RUN_BITS-1:0]   run_nxt;
  logic [gqcs_pkg::RUN_BITS-1:0]   target_w;
  logic [gqcs_pkg::RUN_BITS-1:0]   above_r;
  logic [gqcs_pkg::RUN_BITS-1:0]   below_r;
  logic                            above_neg_r;
  logic                            nearer_here;
  logic signed [gqcs_pkg::LVL_BITS-1:0] level_idx;

  // divider
  logic [gqcs_pkg::PIX_BITS-1:0]   rem_r;
  logic [gqcs_pkg::PIX_BITS-1:0]   quo_r;
  logic [gqcs_pkg::DIV_CNT_BITS-1:0] div_cnt_r;
  logic [gqcs_pkg::PIX_BITS+gqcs_pkg::PIX_BITS-1:0] map_num;
  logic [gqcs_pkg::PIX_BITS:0]     rem_sh;
  logic [gqcs_pkg::PIX_BITS:0]     div_den;
  logic                            div_ge;
  logic [gqcs_pkg::PIX_BITS:0]     rem_sub;

  logic [gqcs_pkg::PIX_BITS-1:0]   res_mapped_r;
  logic                            res_report_r;

  logic                            out_valid_r;
  logic [gqcs_pkg::PIX_BITS-1:0]   out_mapped_r;
  logic signed [gqcs_pkg::LVL_BITS-1:0] out_level_r;
  logic                            out_report_r;

  logic in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign mem_raddr = (state_r == S_W_RD) ? idx_r : in_pixel;
  assign bin_val   = rd_vld_r ? rd_data_r : '0;
  assign bin_inc   = (bin_val == gqcs_pkg::COUNT_MAX) ? bin_val
                                                      : bin_val + gqcs_pkg::COUNT_BITS'(1);
  assign mem_we    = (state_r == S_ACC_UPD);

  assign q_clamp = (quantile_r > gqcs_pkg::FULL_SCALE) ? gqcs_pkg::FULL_SCALE : quantile_r;

  assign run_nxt  = run_r + gqcs_pkg::RUN_BITS'(prod_r);
  assign target_w = gqcs_pkg::RUN_BITS'(target_r);

  // walk ended below the target only when capped at the top bin
  assign nearer_here = above_neg_r || (above_r < below_r);
  assign level_idx   = $signed({1'b0, idx_r});

  // pixel * 255 as (pixel << 8) - pixel
  assign map_num = {pix_r, gqcs_pkg::PIX_BITS'(0)}
                 - {gqcs_pkg::PIX_BITS'(0), pix_r};
  assign rem_sh  = {rem_r, quo_r[gqcs_pkg::PIX_BITS-1]};
  assign div_den = {1'b0, white_r[gqcs_pkg::PIX_BITS-1:0]};
  assign div_ge  = (rem_sh >= div_den);
  assign rem_sub = rem_sh - div_den;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pix_r] <= bin_inc;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_raddr];
    rd_vld_r  <= bin_vld_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      quantile_r  <= gqcs_pkg::Q_RESET;
      total_r     <= '0;
      white_r     <= gqcs_pkg::WL_RESET;
      bin_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantile_r <= cfg_wdata;
      end
      // the emit state drives the output register itself
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pix_r  <= in_pixel;
            last_r <= in_last;
            if (in_mode == gqcs_pkg::MODE_ACC) begin
              if (total_r != gqcs_pkg::COUNT_MAX) begin
                total_r <= total_r + gqcs_pkg::COUNT_BITS'(1);
              end
              state_r <= S_ACC_UPD;
            end else begin
              state_r <= S_MAP;
            end
          end
        end
        S_ACC_UPD: begin
          bin_vld_r[pix_r] <= 1'b1;
          state_r <= last_r ? S_TGT : S_IDLE;
        end
        S_TGT: begin
          target_r <= gqcs_pkg::TGT_BITS'(total_r) * gqcs_pkg::TGT_BITS'(q_clamp);
          run_r    <= '0;
          prev_r   <= '0;
          idx_r    <= '0;
          state_r  <= S_W_RD;
        end
        S_W_RD: begin
          state_r <= S_W_MUL;
        end
        S_W_MUL: begin
          prod_r  <= gqcs_pkg::TGT_BITS'(bin_val) * gqcs_pkg::TGT_BITS'(gqcs_pkg::FULL_SCALE);
          state_r <= S_W_ADD;
        end
        S_W_ADD: begin
          run_r  <= run_nxt;
          prev_r <= run_r;
          if (run_nxt <= target_w && idx_r != gqcs_pkg::LAST_BIN) begin
            idx_r   <= idx_r + gqcs_pkg::BIN_BITS'(1);
            state_r <= S_W_RD;
          end else begin
            state_r <= S_DIF;
          end
        end
        S_DIF: begin
          above_neg_r <= (run_r < target_w);
          above_r     <= run_r - target_w;
          below_r     <= target_w - prev_r;
          state_r     <= S_FIN;
        end
        S_FIN: begin
          white_r      <= nearer_here ? level_idx
                                      : level_idx - gqcs_pkg::LVL_BITS'(1);
          bin_vld_r    <= '0;
          total_r      <= '0;
          res_mapped_r <= '0;
          res_report_r <= 1'b1;
          state_r      <= S_EMIT;
        end
        S_MAP: begin
          res_report_r <= 1'b0;
          if (pix_r == '0) begin
            res_mapped_r <= '0;
            state_r      <= S_EMIT;
          end else if ($signed({1'b0, pix_r}) > white_r) begin
            res_mapped_r <= gqcs_pkg::PIX_MAX;
            state_r      <= S_EMIT;
          end else begin
            // quotient fits in 8 bits, so the high byte is already below the divisor
            rem_r     <= map_num[2*gqcs_pkg::PIX_BITS-1:gqcs_pkg::PIX_BITS];
            quo_r     <= map_num[gqcs_pkg::PIX_BITS-1:0];
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r     <= div_ge ? rem_sub[gqcs_pkg::PIX_BITS-1:0]
                              : rem_sh[gqcs_pkg::PIX_BITS-1:0];
          quo_r     <= {quo_r[gqcs_pkg::PIX_BITS-2:0], div_ge};
          div_cnt_r <= div_cnt_r + gqcs_pkg::DIV_CNT_BITS'(1);
          if (div_cnt_r == gqcs_pkg::DIV_CNT_BITS'(gqcs_pkg::DIV_STEPS - 1)) begin
            res_mapped_r <= {quo_r[gqcs_pkg::PIX_BITS-2:0], div_ge};
            state_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_mapped_r <= res_mapped_r;
            out_level_r  <= white_r;
            out_report_r <= res_report_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mapped_pixel    = out_mapped_r;
  assign out_quantile_level  = out_level_r;
  assign out_is_level_report = out_report_r;

  // the walk never passes a bin whose running sum was already above the target
  a_prev_le_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIF) |-> (prev_r <= target_w))
    else $error("search: previous running sum above target");

  a_hist_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (bin_vld_r == '0))
    else $error("histogram not cleared after level search");

  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_report_r) |-> (out_mapped_r == '0))
    else $error("level report carries nonzero mapped pixel");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r) |-> (out_level_r >= -9'sd1))
    else $error("quantile level below -1");

endmodule
